// ----- rtl/hcd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, constants and helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

   localparam int LengthBits = 32;
   localparam int CountBits  = 32;

   localparam logic [7:0] CharCr = 8'h0D;
   localparam logic [7:0] CharLf = 8'h0A;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_EXT     = 3'd1,
      PH_SIZE_LF = 3'd2,
      PH_DATA    = 3'd3,
      PH_DATA_CR = 3'd4,
      PH_DATA_LF = 3'd5,
      PH_DONE    = 3'd6,
      PH_ERROR   = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       body_start;
   } item_type;

   typedef struct packed {
      kind_type               result_kind;
      logic [7:0]             out_byte;
      logic [CountBits-1:0]   body_length;
   } result_type;

   // bit 4 flags a hex digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// ----- rtl/hcd_if.sv -----
// ----------------------------------------------------------------------------
// hcd_req_if / hcd_rsp_if
// Valid/ready channels carrying raw body bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface hcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       body_start;

   modport source (output valid, output data_byte, output body_start, input ready);
   modport sink (input valid, input data_byte, input body_start, output ready);
endinterface

interface hcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  out_byte;
   logic [31:0] body_length;

   modport source (output valid, output result_kind, output out_byte,
                   output body_length, input ready);
   modport sink (input valid, input result_kind, input out_byte,
                 input body_length, output ready);
endinterface

// ----- rtl/hcd_in_reg.sv -----
// ----------------------------------------------------------------------------
// hcd_in_reg
// Input register: holds one accepted byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module hcd_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  hcd_pkg::item_type in_item,
   output logic              in_ready,
   input  logic              advance,
   output logic              item_valid,
   output hcd_pkg::item_type item
);
   import hcd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || advance;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

// ----- rtl/hcd_core.sv -----
// ----------------------------------------------------------------------------
// hcd_core
// Framing state machine: size line, payload and CR LF checks, byte count, plus a pass-through mode.
// ----------------------------------------------------------------------------
module hcd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                fire,
   input  hcd_pkg::item_type   item,
   output logic                res_valid,
   output hcd_pkg::result_type result
);
   import hcd_pkg::*;

   phase_type             phase_ff, phase_in, cur_phase;
   logic [LengthBits-1:0] rem_ff, rem_in, cur_rem, rem_dec;
   logic                  seen_ff, seen_in, cur_seen;
   logic [CountBits-1:0]  count_ff, count_in, cur_count, count_inc;
   logic                  enable_ff;
   logic [4:0]            hex;
   logic [7:0]            c;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         enable_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         rem_ff   <= '0;
         seen_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         seen_ff  <= seen_in;
         count_ff <= count_in;
      end
   end

   assign c         = item.data_byte;
   assign hex       = hex_digit(c);
   assign cur_phase = item.body_start ? PH_SIZE : phase_ff;
   assign cur_rem   = item.body_start ? '0 : rem_ff;
   assign cur_seen  = item.body_start ? 1'b0 : seen_ff;
   assign cur_count = item.body_start ? '0 : count_ff;
   assign rem_dec   = cur_rem - 1'b1;
   assign count_inc = cur_count + 1'b1;

   always_comb begin
      phase_in           = phase_ff;
      rem_in             = rem_ff;
      seen_in            = seen_ff;
      count_in           = count_ff;
      res_valid          = 1'b0;
      result.result_kind = KIND_BYTE;
      result.out_byte    = 8'd0;
      result.body_length = cur_count;
      if (fire) begin
         phase_in = cur_phase;
         rem_in   = cur_rem;
         seen_in  = cur_seen;
         count_in = cur_count;
         if (!enable_ff) begin
            count_in           = count_inc;
            res_valid          = 1'b1;
            result.out_byte    = c;
            result.body_length = count_inc;
         end else begin
            unique case (cur_phase)
               PH_SIZE: begin
                  if (hex[4]) begin
                     // size must still fit after shifting in one more digit
                     if (|cur_rem[LengthBits-1 -: 4]) begin
                        phase_in           = PH_ERROR;
                        res_valid          = 1'b1;
                        result.result_kind = KIND_ERROR;
                     end else begin
                        rem_in  = {cur_rem[LengthBits-5:0], hex[3:0]};
                        seen_in = 1'b1;
                     end
                  end else if (!cur_seen) begin
                     phase_in           = PH_ERROR;
                     res_valid          = 1'b1;
                     result.result_kind = KIND_ERROR;
                  end else begin
                     phase_in = (c == CharCr) ? PH_SIZE_LF : PH_EXT;
                  end
               end
               PH_EXT: begin
                  if (c == CharCr) begin
                     phase_in = PH_SIZE_LF;
                  end
               end
               PH_SIZE_LF: begin
                  if (c != CharLf) begin
                     phase_in           = PH_ERROR;
                     res_valid          = 1'b1;
                     result.result_kind = KIND_ERROR;
                  end else if (cur_rem == '0) begin
                     phase_in           = PH_DONE;
                     res_valid          = 1'b1;
                     result.result_kind = KIND_END;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  count_in           = count_inc;
                  rem_in             = rem_dec;
                  res_valid          = 1'b1;
                  result.out_byte    = c;
                  result.body_length = count_inc;
                  if (rem_dec == '0) begin
                     phase_in = PH_DATA_CR;
                  end
               end
               PH_DATA_CR: begin
                  if (c != CharCr) begin
                     phase_in           = PH_ERROR;
                     res_valid          = 1'b1;
                     result.result_kind = KIND_ERROR;
                  end else begin
                     phase_in = PH_DATA_LF;
                  end
               end
               PH_DATA_LF: begin
                  if (c != CharLf) begin
                     phase_in           = PH_ERROR;
                     res_valid          = 1'b1;
                     result.result_kind = KIND_ERROR;
                  end else begin
                     phase_in = PH_SIZE;
                     rem_in   = '0;
                     seen_in  = 1'b0;
                  end
               end
               PH_DONE, PH_ERROR: begin
                  // trailers and bytes after an error are dropped
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// ----- rtl/hcd_out_reg.sv -----
// ----------------------------------------------------------------------------
// hcd_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module hcd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  hcd_pkg::result_type load_result,
   input  logic                out_ready,
   output logic                out_valid,
   output hcd_pkg::result_type out_result,
   output logic                advance
);
   import hcd_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign advance    = !valid_ff || out_ready;
   assign valid_in   = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

endmodule

// ----- rtl/http_chunked_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// http_chunked_decoder_unit
// Chunked transfer decoder for an HTTP message body, one byte per transfer.
// ----------------------------------------------------------------------------
// Raw body bytes enter on req_bus, with body_start set on the first byte of
// each new body. Decoded results leave on rsp_bus: a payload byte, an end of
// body carrying the decoded length, or a framing error. Size-line, CR LF and
// trailer bytes give no payload byte on rsp_bus in chunked mode.
// csr_wr_data written with csr_wr_en selects chunked decoding (1) or plain
// pass-through (0); write it only while the block is idle.
// A byte passes from the req_bus transfer into the input register, then through
// the decode logic into the result register that drives rsp_bus.
// Throughput is one byte per cycle while rsp_bus does not stall; the framing
// state machine updates once per byte.
// Reset clears both registers, enables chunked mode and puts the decoder at
// the start of a size line.
// When the receiver stalls, the result register holds its result and the
// input register keeps its byte or takes one if empty; req_bus.ready then drops.
// ----------------------------------------------------------------------------
module http_chunked_decoder_unit (
   input logic      clock,
   input logic      reset,
   hcd_req_if.sink  req_bus,
   hcd_rsp_if.source rsp_bus,
   input logic      csr_wr_en,
   input logic      csr_wr_data
);
   import hcd_pkg::*;

   item_type   req_item, item;
   result_type core_result, out_result;
   logic       item_valid, advance, fire, res_valid;

   assign req_item.data_byte  = req_bus.data_byte;
   assign req_item.body_start = req_bus.body_start;
   assign fire                = item_valid && advance;

   hcd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_item    (req_item),
      .in_ready   (req_bus.ready),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   hcd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (item),
      .res_valid   (res_valid),
      .result      (core_result)
   );

   hcd_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (fire && res_valid),
      .load_result (core_result),
      .out_ready   (rsp_bus.ready),
      .out_valid   (rsp_bus.valid),
      .out_result  (out_result),
      .advance     (advance)
   );

   assign rsp_bus.result_kind = out_result.result_kind;
   assign rsp_bus.out_byte    = out_result.out_byte;
   assign rsp_bus.body_length = out_result.body_length;

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!item_valid && !rsp_bus.valid))
      else $error("pipeline not empty after reset");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !advance) |=> (item_valid && $stable(item)))
      else $error("buffered byte lost while result stage stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.result_kind == KIND_BYTE ||
                         rsp_bus.result_kind == KIND_END ||
                         rsp_bus.result_kind == KIND_ERROR))
      else $error("undefined result kind");

   a_end_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.result_kind != KIND_BYTE) |-> (rsp_bus.out_byte == 8'd0))
      else $error("non-payload result carries a byte");
`endif

endmodule
